// ----- rtl/sefb_pkg.sv -----
// ----------------------------------------------------------------------------
// sefb_pkg
// Shared types and constants of the SOH/STX/ETX frame builder.
// ----------------------------------------------------------------------------
package sefb_pkg;

  // Payload bytes per full frame (1 to 255)
  localparam logic [7:0] FRAME_DATA_SIZE = 8'd16;

  localparam logic [7:0] SOH_BYTE = 8'h01;
  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;

  // Depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One classified item, as handed from the front to the back
  typedef struct packed {
    logic [7:0]  data;
    logic        open_frame;   // header goes out before the data byte
    logic        close_frame;  // ETX and checksum follow the data byte
    logic [31:0] frame_number;
  } sefb_cmd_t;

endpackage

// ----- rtl/sefb_front.sv -----
// ----------------------------------------------------------------------------
// sefb_front
// Takes file bytes, tracks frame fill and number, and queues one command per
// item saying whether it opens and/or closes a frame.
// ----------------------------------------------------------------------------
module sefb_front import sefb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       end_of_file,
  output logic       cmd_push,
  input  logic       cmd_full,
  output sefb_cmd_t  cmd
);

  logic [31:0] frame_number;
  logic [7:0]  payload_count;
  logic [7:0]  count_inc;
  logic        take;

  assign full      = cmd_full;
  assign take      = push && !cmd_full;
  assign cmd_push  = take;
  assign count_inc = payload_count + 8'd1;

  always_comb begin
    cmd.data         = data_byte;
    cmd.open_frame   = (payload_count == 8'd0);
    cmd.close_frame  = end_of_file || (count_inc >= FRAME_DATA_SIZE);
    cmd.frame_number = frame_number;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_number  <= '0;
      payload_count <= '0;
    end else if (take) begin
      if (cmd.close_frame) begin
        payload_count <= '0;
        frame_number  <= end_of_file ? 32'd0 : frame_number + 32'd1;
      end else begin
        payload_count <= count_inc;
      end
    end
  end

endmodule

// ----- rtl/sefb_queue.sv -----
// ----------------------------------------------------------------------------
// sefb_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module sefb_queue import sefb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  sefb_cmd_t wr_cmd,
  output logic      full,
  input  logic      rd_en,
  output sefb_cmd_t rd_cmd,
  output logic      not_empty
);

  sefb_cmd_t           mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   fill;
  logic                do_wr;
  logic                do_rd;

  assign full      = (fill == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_cmd    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- rtl/sefb_back.sv -----
// ----------------------------------------------------------------------------
// sefb_back
// Byte sequencer: walks header, data, trailer for each command and keeps the
// frame checksum; one output register towards the result side.
// ----------------------------------------------------------------------------
module sefb_back import sefb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  sefb_cmd_t  cmd_head,
  output logic       cmd_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       frame_end,
  output logic       last_in_run
);

  typedef enum logic [8:0] {
    PH_SOH  = 9'b000000001,
    PH_FN0  = 9'b000000010,
    PH_FN1  = 9'b000000100,
    PH_FN2  = 9'b000001000,
    PH_FN3  = 9'b000010000,
    PH_STX  = 9'b000100000,
    PH_DATA = 9'b001000000,
    PH_ETX  = 9'b010000000,
    PH_CHK  = 9'b100000000
  } sefb_phase_t;

  sefb_phase_t phase;
  sefb_phase_t phase_next;
  sefb_cmd_t   cur;
  logic        busy;
  logic [7:0]  sum;
  logic [7:0]  byte_next;
  logic        out_valid;
  logic        adv;
  logic        done;
  logic        load;
  logic        run_end;

  assign adv     = busy && (!out_valid || pop);
  assign run_end = (phase == PH_CHK) || ((phase == PH_DATA) && !cur.close_frame);
  assign done    = adv && run_end;
  assign load    = cmd_valid && (!busy || done);
  assign cmd_pop = load;
  assign empty   = !out_valid;

  always_comb begin
    phase_next = phase;
    byte_next  = cur.data;
    case (phase)
      PH_SOH: begin
        byte_next  = SOH_BYTE;
        phase_next = PH_FN0;
      end
      PH_FN0: begin
        byte_next  = cur.frame_number[7:0];
        phase_next = PH_FN1;
      end
      PH_FN1: begin
        byte_next  = cur.frame_number[15:8];
        phase_next = PH_FN2;
      end
      PH_FN2: begin
        byte_next  = cur.frame_number[23:16];
        phase_next = PH_FN3;
      end
      PH_FN3: begin
        byte_next  = cur.frame_number[31:24];
        phase_next = PH_STX;
      end
      PH_STX: begin
        byte_next  = STX_BYTE;
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        byte_next  = cur.data;
        phase_next = PH_ETX;
      end
      PH_ETX: begin
        byte_next  = ETX_BYTE;
        phase_next = PH_CHK;
      end
      PH_CHK: begin
        byte_next  = 8'd0 - sum;
        phase_next = PH_SOH;
      end
      default: begin
        byte_next  = cur.data;
        phase_next = PH_SOH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= cmd_head;
    end
    if (adv) begin
      out_byte    <= byte_next;
      frame_end   <= (phase == PH_CHK);
      last_in_run <= run_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase     <= PH_SOH;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        busy  <= 1'b1;
        phase <= cmd_head.open_frame ? PH_SOH : PH_DATA;
      end else if (done) begin
        busy  <= 1'b0;
      end else if (adv) begin
        phase <= phase_next;
      end

      // SOH restarts the sum; the checksum byte itself is not summed
      if (adv) begin
        if (phase == PH_SOH) begin
          sum <= SOH_BYTE;
        end else if (phase != PH_CHK) begin
          sum <= sum + byte_next;
        end
      end

      if (adv) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/stx_etx_frame_builder_top.sv -----
// ----------------------------------------------------------------------------
// stx_etx_frame_builder_top
// Frame builder: file bytes in, SOH/number/STX/data/ETX/checksum bytes out.
// ----------------------------------------------------------------------------
// Both sides look like a queue. The front classifies each file byte (does it
// open a frame, does it close one) and stamps the frame number; the back
// sends one framed byte per cycle while the result side pops, through a
// single output register. An item that opens a frame costs six header bytes,
// one that closes it two trailer bytes, so an item yields 1 to 9 output
// bytes; the output port, one byte a cycle, sets the rate. A four-entry
// command queue between front and back lets input keep arriving while a
// header or trailer is going out. No clearing pass after reset.
// ----------------------------------------------------------------------------
module stx_etx_frame_builder_top import sefb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       end_of_file,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       frame_end,
  output logic       last_in_run
);

  sefb_cmd_t front_cmd;
  sefb_cmd_t head_cmd;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;

  // Front: classification and frame counters
  sefb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .data_byte   (data_byte),
    .end_of_file (end_of_file),
    .cmd_push    (q_push),
    .cmd_full    (q_full),
    .cmd         (front_cmd)
  );

  // Decoupling queue
  sefb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (q_push),
    .wr_cmd    (front_cmd),
    .full      (q_full),
    .rd_en     (q_pop),
    .rd_cmd    (head_cmd),
    .not_empty (q_valid)
  );

  // Back: byte sequencer and checksum
  sefb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd_head    (head_cmd),
    .cmd_pop     (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .frame_end   (frame_end),
    .last_in_run (last_in_run)
  );

endmodule

// ----- rtl/sefb_checker.sv -----
// ----------------------------------------------------------------------------
// sefb_checker
// Port-level checks of the frame builder, bound to the top level.
// ----------------------------------------------------------------------------
module sefb_checker import sefb_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       frame_end,
  input logic       last_in_run
);

  logic out_take;
  logic frame_due;  // next accepted byte must start a frame

  assign out_take = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_due <= 1'b1;
    end else if (out_take) begin
      frame_due <= frame_end;
    end
  end

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_end) |-> last_in_run)
    else $error("checksum byte not marked last of its item");

  a_frame_starts_soh: assert property (@(posedge clk) disable iff (rst)
    (out_take && frame_due) |-> (out_byte == SOH_BYTE && !frame_end))
    else $error("frame does not start with SOH");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(frame_end)))
    else $error("result changed while stalled");

endmodule

bind stx_etx_frame_builder_top sefb_checker u_sefb_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .out_byte    (out_byte),
  .frame_end   (frame_end),
  .last_in_run (last_in_run)
);
